FILE: rtl/slid_pkg.sv
package slid_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 3;

    // Command codes on the input channel. Code 3 has no meaning.
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd2;

    // Status codes on the output channel.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ELEMENT   = 3'd5;

    // Operation that the controller asks of the datapath in one cycle.
    typedef enum logic [2:0] {
        OP_NONE       = 3'd0,
        OP_INSERT     = 3'd1,
        OP_DELETE     = 3'd2,
        OP_SHOW_EMPTY = 3'd3,
        OP_ROTATE     = 3'd4
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;    // what to do with the list and the output word
        logic   last;  // last flag of the word loaded this cycle
    } t_dp_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

FILE: rtl/slid_datapath.sv
module slid_datapath #(
    parameter int CAPACITY = slid_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  slid_pkg::t_dp_ctrl                  i_ctrl,
    input  logic signed [slid_pkg::VALUE_W-1:0] i_value,
    output slid_pkg::t_dp_stat                  o_stat,
    output logic        [CW-1:0]                o_count,
    output logic        [slid_pkg::STATUS_W-1:0] o_status,
    output logic signed [slid_pkg::VALUE_W-1:0] o_result_value,
    output logic                                o_last
);
    import slid_pkg::*;

    logic signed [VALUE_W-1:0]  r_cell [CAPACITY];
    logic signed [VALUE_W-1:0]  n_cell [CAPACITY];
    logic        [CW-1:0]       r_count, n_count;
    logic        [STATUS_W-1:0] r_status, n_status;
    logic signed [VALUE_W-1:0]  r_value, n_value;
    logic                       r_last, n_last;

    logic [CAPACITY-1:0] w_used;  // entry holds a stored value
    logic [CAPACITY-1:0] w_le;    // stored value <= input, entry in use
    logic [CAPACITY-1:0] w_lt;    // stored value <  input, entry in use
    logic [CAPACITY-1:0] w_eq;    // stored value == input, entry in use
    logic                w_full, w_empty, w_found;

    // One comparator cell per entry; the list is sorted, so the flags form
    // a run of ones from entry 0 and the insert or delete point follows.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_used[i] = CW'(i) < r_count;
            w_le[i]   = w_used[i] && (r_cell[i] <= i_value);
            w_lt[i]   = w_used[i] && (r_cell[i] <  i_value);
            w_eq[i]   = w_used[i] && (r_cell[i] == i_value);
        end
    end

    assign w_full  = r_count == CW'(CAPACITY);
    assign w_empty = r_count == '0;
    assign w_found = |w_eq;

    always_comb begin
        n_cell   = r_cell;
        n_count  = r_count;
        n_status = r_status;
        n_value  = r_value;
        n_last   = r_last;
        case (i_ctrl.op)
            OP_INSERT: begin
                n_value = i_value;
                n_last  = i_ctrl.last;
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_INSERTED;
                    n_count  = r_count + CW'(1);
                    if (!w_le[0]) begin
                        n_cell[0] = i_value;
                    end
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (!w_le[i]) begin
                            if (w_le[i-1]) begin
                                n_cell[i] = i_value;
                            end else begin
                                n_cell[i] = r_cell[i-1];
                            end
                        end
                    end
                end
            end
            OP_DELETE: begin
                n_value = i_value;
                n_last  = i_ctrl.last;
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else if (!w_found) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_status = ST_DELETED;
                    n_count  = r_count - CW'(1);
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (!w_lt[i]) begin
                            n_cell[i] = r_cell[i+1];
                        end
                    end
                end
            end
            OP_SHOW_EMPTY: begin
                n_status = ST_EMPTY;
                n_value  = '0;
                n_last   = i_ctrl.last;
            end
            OP_ROTATE: begin
                // Head goes out and to the tail of the used entries.
                n_status = ST_ELEMENT;
                n_value  = r_cell[0];
                n_last   = i_ctrl.last;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (CW'(i) + CW'(1) == r_count) begin
                        n_cell[i] = r_cell[0];
                    end else if (CW'(i) + CW'(1) < r_count) begin
                        n_cell[i] = r_cell[(i + 1) % CAPACITY];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_cell   <= n_cell;
        r_status <= n_status;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    assign o_stat.full     = w_full;
    assign o_stat.empty    = w_empty;
    assign o_count         = r_count;
    assign o_status        = r_status;
    assign o_result_value  = r_value;
    assign o_last          = r_last;

endmodule

FILE: rtl/slid_ctrl.sv
module slid_ctrl #(
    parameter int CAPACITY = slid_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [slid_pkg::CMD_W-1:0]     i_command,
    output logic                           o_valid,
    input  logic                           i_stall,
    input  slid_pkg::t_dp_stat             i_stat,
    input  logic [CW-1:0]                  i_count,
    output slid_pkg::t_dp_ctrl             o_ctrl
);
    import slid_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DISP = 2'b10
    } t_state;

    t_state      r_state, n_state;
    logic [CW-1:0] r_remain, n_remain;
    logic        r_valid, n_valid;
    logic        w_out_free, w_accept;

    // The output word may be replaced when it is empty or taken this edge.
    assign w_out_free = !r_valid || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_valid && !o_stall;

    always_comb begin
        n_state     = r_state;
        n_remain    = r_remain;
        o_ctrl.op   = OP_NONE;
        o_ctrl.last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        CMD_INSERT: o_ctrl.op = OP_INSERT;
                        CMD_DELETE: o_ctrl.op = OP_DELETE;
                        CMD_DISPLAY: begin
                            if (i_stat.empty) begin
                                o_ctrl.op = OP_SHOW_EMPTY;
                            end else begin
                                n_state  = S_DISP;
                                n_remain = i_count;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DISP: begin
                if (w_out_free) begin
                    o_ctrl.op   = OP_ROTATE;
                    o_ctrl.last = r_remain == CW'(1);
                    n_remain    = r_remain - CW'(1);
                    if (r_remain == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_ctrl.op != OP_NONE) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_remain <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_remain <= n_remain;
            r_valid  <= n_valid;
        end
    end

    assign o_valid = r_valid;

endmodule

FILE: rtl/sorted_list_insert_delete.sv
// Channel | Direction | Handshake                 | Word
// --------+-----------+---------------------------+------------------------------
// input   | in        | i_valid / o_stall         | i_command, i_value
// output  | out       | o_valid / i_stall         | o_status, o_result_value, o_last
//
// For an insert or a delete every stored entry has its own comparator, and the list
// shifts by one place around the insert or delete point. A display takes the word and
// gives one result per stored value, the list rotating through its head and waiting
// while the output stalls; an empty list gives one. The input is stalled meanwhile.
// Reset is synchronous and active low; it empties the list and the output.
// A new word is taken while a result waits, as soon as that result is taken.
module sorted_list_insert_delete #(
    parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic        [slid_pkg::CMD_W-1:0]    i_command,
    input  logic signed [slid_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic        [slid_pkg::STATUS_W-1:0] o_status,
    output logic signed [slid_pkg::VALUE_W-1:0]  o_result_value,
    output logic                                 o_last
);
    import slid_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_dp_ctrl      w_ctrl;
    t_dp_stat      w_stat;
    logic [CW-1:0] w_count;

    // The controller sequences commands; the datapath holds the list.
    slid_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_command (i_command),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .i_stat    (w_stat),
        .i_count   (w_count),
        .o_ctrl    (w_ctrl)
    );

    slid_datapath #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_ctrl),
        .i_value        (i_value),
        .o_stat         (w_stat),
        .o_count        (w_count),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_last         (o_last)
    );

    // The fill level never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(CAPACITY))
        else $error("list fill level above capacity");

    // An insert into a list with room grows it by exactly one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_command == CMD_INSERT && !w_stat.full)
        |=> (w_count == $past(w_count) + CW'(1)))
        else $error("insert did not grow the list");

    // A delete from an empty list reports empty in the next cycle.
    a_delete_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_command == CMD_DELETE && w_stat.empty)
        |=> (o_valid && o_status == ST_EMPTY && o_last))
        else $error("delete from empty list not reported");

endmodule

FILE: tb/sorted_list_insert_delete_tb.sv
`timescale 1ns / 100ps

module sorted_list_insert_delete_tb;

    import slid_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;

    // Command code 3 has no meaning; the block must swallow it without a result.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // Ample for the slowest correct run: about 150 words, each display
    // streaming up to a full list while the receiver stalls at random.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_list_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic [CMD_W-1:0]          i_command = CMD_INSERT;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [STATUS_W-1:0]       o_status;
    logic signed [VALUE_W-1:0] o_result_value;
    logic                      o_last;

    // Our own copy of the list, smallest first, and the results still owed.
    logic signed [VALUE_W-1:0] list_shadow[$];
    t_list_result              pending_results[$];
    t_list_result              head_result;

    int          err_count = 0;
    int unsigned cycle_count;
    // While set, neither side idles, so words follow back to back.
    bit          no_idle = 1'b0;

    sorted_list_insert_delete #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_last         (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Updates the shadow list for one accepted word and queues the results
    // that the block owes for it, in the order it must give them.
    task automatic apply_list_command(input logic [CMD_W-1:0] cmd,
                                      input logic signed [VALUE_W-1:0] val);
        int pos;
        case (cmd)
            CMD_INSERT: begin
                if (list_shadow.size() >= LIST_CAP) begin
                    pending_results.push_back('{ST_FULL, val, 1'b1});
                end else begin
                    // Equal values go after those already stored.
                    pos = 0;
                    while (pos < list_shadow.size() && list_shadow[pos] <= val) pos++;
                    list_shadow.insert(pos, val);
                    pending_results.push_back('{ST_INSERTED, val, 1'b1});
                end
            end
            CMD_DELETE: begin
                if (list_shadow.size() == 0) begin
                    pending_results.push_back('{ST_EMPTY, val, 1'b1});
                end else begin
                    pos = 0;
                    while (pos < list_shadow.size() && list_shadow[pos] != val) pos++;
                    if (pos >= list_shadow.size()) begin
                        pending_results.push_back('{ST_NOT_FOUND, val, 1'b1});
                    end else begin
                        pending_results.push_back('{ST_DELETED, list_shadow[pos], 1'b1});
                        list_shadow.delete(pos);
                    end
                end
            end
            CMD_DISPLAY: begin
                if (list_shadow.size() == 0) begin
                    pending_results.push_back('{ST_EMPTY, '0, 1'b1});
                end else begin
                    foreach (list_shadow[k]) begin
                        pending_results.push_back('{ST_ELEMENT, list_shadow[k],
                                                    k == list_shadow.size() - 1});
                    end
                end
            end
            default: begin
                // The unused code changes nothing and gives nothing.
            end
        endcase
    endtask

    // Sends one word. It is called just after the clock rises; valid stays high
    // between words unless a random gap is taken first.
    task automatic send_word(input logic [CMD_W-1:0] cmd,
                             input logic signed [VALUE_W-1:0] val);
        int gap;
        gap = 0;
        while (!no_idle && $urandom_range(0, 99) < 23) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_value   <= val;
        do @(posedge i_clk); while (o_stall);
        apply_list_command(cmd, val);
    endtask

    // Holds off the sender until every owed result has been taken; the last
    // word is withdrawn first so that it is not taken a second time.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Values for random words. Asking for a hit returns a stored value, so
    // that deletes find something; otherwise a mix of the full range, a
    // narrow band that gives many duplicates, and the extremes.
    function automatic logic signed [VALUE_W-1:0] pick_value(input bit want_hit);
        int roll;
        roll = $urandom_range(0, 99);
        if (want_hit && list_shadow.size() > 0)
            return list_shadow[$urandom_range(0, list_shadow.size() - 1)];
        if (roll < 35) return $urandom;
        if (roll < 80) return int'($urandom_range(0, 16)) - 8;
        case (roll % 4)
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    // An empty list: display and delete both report it, and the unused
    // command must give no result at all.
    task automatic test_empty_list();
        send_word(CMD_DISPLAY, VAL_MAX);
        send_word(CMD_DELETE, VAL_MIN);
        send_word(CMD_UNUSED, VAL_MAX);
        wait_drained();
    endtask

    // Ordering across the signed extremes, duplicates, a delete that hits,
    // one that misses, and a delete of the smallest entry.
    task automatic test_order_and_delete();
        send_word(CMD_INSERT, VAL_MAX);
        send_word(CMD_INSERT, VAL_MIN);
        send_word(CMD_INSERT, '0);
        send_word(CMD_INSERT, -1);
        send_word(CMD_INSERT, 7);
        send_word(CMD_INSERT, 7);
        send_word(CMD_DISPLAY, '0);
        send_word(CMD_DELETE, 7);
        send_word(CMD_DELETE, 12345);
        send_word(CMD_DELETE, VAL_MIN);
        wait_drained();
    endtask

    // Fills the list, overflows it, and streams the longest display.
    task automatic test_full_list();
        while (list_shadow.size() < LIST_CAP) send_word(CMD_INSERT, pick_value(1'b0));
        send_word(CMD_INSERT, VAL_MIN);
        send_word(CMD_DISPLAY, VAL_MIN);
        send_word(CMD_DELETE, VAL_MAX);
        wait_drained();
    endtask

    // Random traffic. The mix swings between mostly inserts and mostly
    // deletes each phase, so the list keeps running between full and empty;
    // the sender waits for all results at every phase boundary.
    task automatic test_random_traffic(input int word_target, input int phase_len);
        int            sent;
        int            insert_pct;
        int            roll;
        logic [CMD_W-1:0] cmd;
        sent       = 0;
        insert_pct = 75;
        while (sent < word_target) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
                cmd = CMD_UNUSED;
            else if (roll < 13)
                cmd = CMD_DISPLAY;
            else if ($urandom_range(0, 99) < insert_pct)
                cmd = CMD_INSERT;
            else
                cmd = CMD_DELETE;
            send_word(cmd, pick_value(cmd == CMD_DELETE && $urandom_range(0, 99) < 70));
            if (cmd != CMD_UNUSED) begin
                sent++;
                if (sent % phase_len == 0) begin
                    insert_pct = 100 - insert_pct;
                    wait_drained();
                end
            end
        end
        wait_drained();
    endtask

    // A stretch with no idling on either side, so that results never wait, and words move
    // on every cycle, except while a display stalls the input.
    task automatic test_back_to_back();
        no_idle = 1'b1;
        test_random_traffic(20, 20);
        no_idle = 1'b0;
    endtask

    // The receiver stalls at random, about 23 percent of the time, except during
    // the back-to-back stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle)
            i_stall <= 1'b0;
        else
            i_stall <= ($urandom_range(0, 99) < 23);
    end

    // Every result taken is compared with the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result: expected none, got status %0d value %0d last %0d",
                         $time, o_status, o_result_value, o_last);
            end else begin
                head_result = pending_results.pop_front();
                if (o_status !== head_result.status) begin
                    err_count++;
                    $display("%0t: status: expected %0d, got %0d",
                             $time, head_result.status, o_status);
                end
                if (o_result_value !== head_result.value) begin
                    err_count++;
                    $display("%0t: result_value: expected %0d, got %0d",
                             $time, head_result.value, o_result_value);
                end
                if (o_last !== head_result.last) begin
                    err_count++;
                    $display("%0t: last: expected %0d, got %0d",
                             $time, head_result.last, o_last);
                end
            end
        end
    end

    // Guard against a hung handshake.
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_order_and_delete();
        test_full_list();
        test_back_to_back();
        test_random_traffic(100, 40);

        i_valid <= 1'b0;
        wait_drained();
        // Let any stray result show itself before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
